@@ rtl/cbcr_pkg.sv @@
// shared types and constants of the circle versus box collision block
`timescale 1ns / 1ps
package cbcr_pkg;

    // config register index (byte address / 4)
    localparam logic [0:0] REG_INSIDE_EPS = 1'b0;
    localparam logic [7:0] EPS_RESET      = 8'd1;

    // normal format
    localparam int NORM_FRAC = 14;
    localparam int Q_W       = 15;
    localparam logic [Q_W-1:0] NORM_ONE_Q = 15'd16384;
    localparam logic signed [15:0] NORM_POS = 16'sd16384;
    localparam logic signed [15:0] NORM_NEG = -16'sd16384;

    // pre-shift of the squared distance, in pairs of bits
    localparam int MAX_HALF_SH = 6;
    localparam int HS_W        = 3;
    localparam int SQ_LIMIT    = 62;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        FACE_LEFT,
        FACE_RIGHT,
        FACE_TOP,
        FACE_BOTTOM
    } face_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

@@ rtl/circle_box_collision_resolve_top.sv @@
// top level of the circle versus axis-aligned box collision block
//
// One item on the s_ channel carries a circle (center, radius) and a box
// (min and max corners) in signed fixed point. One result item per input
// leaves on the m_ channel: hit flag, penetration depth and a unit push-out
// normal with 14 fraction bits. Results keep the input order.
// The front pipeline (3 stages) clamps, classifies and squares; a 4-entry
// queue decouples it from the back pipeline, which runs a bit-per-stage
// square root (RAD_E/2 stages) and two 15-stage restoring dividers.
// The pipeline takes one item per cycle while m_tready stays high.
// When m_tready is low the back pipeline holds, the queue fills and then
// s_tready drops; nothing is lost. Reset (aresetn low at a clock edge)
// empties all stages and sets inside_epsilon to 1. inside_epsilon lies at
// APB byte address 0; pready is always high.
`timescale 1ns / 1ps
module circle_box_collision_resolve_top #(
    parameter int COORD_WIDTH = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    // center_x, center_y, circle_radius, box_min_x, box_min_y, box_max_x, box_max_y
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [((7*COORD_WIDTH-1)+7)/8*8-1:0] s_tdata,
    // hit, pen_depth, normal_x, normal_y
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [((COORD_WIDTH+33)+7)/8*8-1:0]  m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cbcr_pkg::*;

    localparam int CW      = COORD_WIDTH;
    localparam int MW      = CW - 1;
    localparam int RAD_RAW = 2 * MW + 13;
    localparam int RAD_C   = (RAD_RAW > SQ_LIMIT) ? SQ_LIMIT : RAD_RAW;
    localparam int RAD_E   = RAD_C + RAD_C % 2;
    localparam int E_W     = CW + 3 * MW + 9 + RAD_E;
    localparam int S_W     = ((7 * CW - 1) + 7) / 8 * 8;
    localparam int M_W     = ((CW + 33) + 7) / 8 * 8;

    logic           eps_sel;
    logic [7:0]     inside_eps_reg;
    logic           push, pop;
    logic [E_W-1:0] push_data, pop_data;
    qstat_t         q_stat;

    assign pready  = 1'b1;
    assign eps_sel = (paddr[2] == REG_INSIDE_EPS);
    assign prdata  = eps_sel ? {24'd0, inside_eps_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_eps_reg <= EPS_RESET;
        end else if (psel && penable && pwrite && pready && eps_sel) begin
            inside_eps_reg <= pwdata[7:0];
        end
    end

    cbcr_front #(
        .CW    (CW),
        .RAD_E (RAD_E),
        .S_W   (S_W),
        .E_W   (E_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    cbcr_queue #(
        .W (E_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    cbcr_back #(
        .CW    (CW),
        .RAD_E (RAD_E),
        .E_W   (E_W),
        .M_W   (M_W)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_stat     (q_stat),
        .pop        (pop),
        .pop_data   (pop_data),
        .inside_eps (inside_eps_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

@@ rtl/cbcr_front.sv @@
// front pipeline: clamp, distance classification, face pick and squared distance
`timescale 1ns / 1ps
module cbcr_front #(
    parameter int CW    = 24,
    parameter int RAD_E = 60,
    parameter int S_W   = 168,
    parameter int E_W   = 171
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_W-1:0]        s_tdata,
    input  cbcr_pkg::qstat_t      q_stat,
    output logic                  push,
    output logic [E_W-1:0]        push_data
);
    import cbcr_pkg::*;

    localparam int MW   = CW - 1;
    localparam int FW   = CW + 1;
    localparam int SQ_W = 2 * MW + 1;

    typedef struct packed {
        logic              miss;
        face_t             face;
        logic [CW-1:0]     fdepth;
        logic [MW-1:0]     r;
        logic              sx;
        logic              sy;
        logic [MW-1:0]     mx;
        logic [MW-1:0]     my;
        logic [HS_W-1:0]   hs;
        logic              dz;
        logic [RAD_E-1:0]  rad;
    } entry_t;

    logic en;
    logic f1_v_reg, f2_v_reg, f3_v_reg;

    // stage 1 inputs
    logic signed [CW-1:0] cx, cy, mnx, mny, mxx, mxy, clx, cly;
    logic [MW-1:0]        r_in;
    logic signed [FW-1:0] dx, dy;
    logic [FW-1:0]        adx, ady;

    logic                 f1_miss_reg, f1_sx_reg, f1_sy_reg;
    logic [MW-1:0]        f1_mx_reg, f1_my_reg, f1_r_reg;
    logic signed [FW-1:0] f1_f_reg [4];

    // stage 2
    face_t                best;
    logic signed [FW-1:0] fb;
    logic signed [FW:0]   fsum;
    logic [CW-1:0]        fdepth;
    logic                 f2_miss_reg, f2_sx_reg, f2_sy_reg;
    logic [MW-1:0]        f2_mx_reg, f2_my_reg, f2_r_reg;
    logic [2*MW-1:0]      f2_px_reg, f2_py_reg, f2_r2_reg;
    face_t                f2_face_reg;
    logic [CW-1:0]        f2_fdepth_reg;

    // stage 3
    logic [SQ_W-1:0]      dsq;
    logic [63:0]          d64;
    logic [HS_W-1:0]      hs;
    entry_t               f3_reg;

    assign en       = !f3_v_reg || !q_stat.full;
    assign s_tready = en;
    assign push     = en && f3_v_reg;
    assign push_data = f3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
        end else if (en) begin
            f1_v_reg <= s_tvalid;
            f2_v_reg <= f1_v_reg;
            f3_v_reg <= f2_v_reg;
        end
    end

    always_comb begin
        cx   = s_tdata[CW-1:0];
        cy   = s_tdata[2*CW-1:CW];
        r_in = s_tdata[3*CW-2:2*CW];
        mnx  = s_tdata[4*CW-2:3*CW-1];
        mny  = s_tdata[5*CW-2:4*CW-1];
        mxx  = s_tdata[6*CW-2:5*CW-1];
        mxy  = s_tdata[7*CW-2:6*CW-1];
        // below min wins over above max for an inverted box
        if (cx < mnx) begin
            clx = mnx;
        end else if (cx > mxx) begin
            clx = mxx;
        end else begin
            clx = cx;
        end
        if (cy < mny) begin
            cly = mny;
        end else if (cy > mxy) begin
            cly = mxy;
        end else begin
            cly = cy;
        end
        dx  = FW'(cx) - FW'(clx);
        dy  = FW'(cy) - FW'(cly);
        adx = dx[FW-1] ? -dx : dx;
        ady = dy[FW-1] ? -dy : dy;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_miss_reg <= (adx >= FW'(r_in)) || (ady >= FW'(r_in));
            f1_sx_reg   <= dx[FW-1];
            f1_sy_reg   <= dy[FW-1];
            f1_mx_reg   <= adx[MW-1:0];
            f1_my_reg   <= ady[MW-1:0];
            f1_r_reg    <= r_in;
            f1_f_reg[0] <= FW'(cx) - FW'(mnx);
            f1_f_reg[1] <= FW'(mxx) - FW'(cx);
            f1_f_reg[2] <= FW'(cy) - FW'(mny);
            f1_f_reg[3] <= FW'(mxy) - FW'(cy);
        end
    end

    // shallowest face, earlier face wins a tie
    always_comb begin
        best = FACE_LEFT;
        fb   = f1_f_reg[0];
        if (f1_f_reg[1] < fb) begin
            best = FACE_RIGHT;
            fb   = f1_f_reg[1];
        end
        if (f1_f_reg[2] < fb) begin
            best = FACE_TOP;
            fb   = f1_f_reg[2];
        end
        if (f1_f_reg[3] < fb) begin
            best = FACE_BOTTOM;
            fb   = f1_f_reg[3];
        end
        fsum = (FW+1)'(fb) + $signed({3'b000, f1_r_reg});
        if (fsum[FW]) begin
            fdepth = '0;
        end else if (fsum[FW-1]) begin
            fdepth = '1;
        end else begin
            fdepth = fsum[CW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f2_miss_reg   <= f1_miss_reg;
            f2_sx_reg     <= f1_sx_reg;
            f2_sy_reg     <= f1_sy_reg;
            f2_mx_reg     <= f1_mx_reg;
            f2_my_reg     <= f1_my_reg;
            f2_r_reg      <= f1_r_reg;
            f2_px_reg     <= (2*MW)'(f1_mx_reg) * (2*MW)'(f1_mx_reg);
            f2_py_reg     <= (2*MW)'(f1_my_reg) * (2*MW)'(f1_my_reg);
            f2_r2_reg     <= (2*MW)'(f1_r_reg) * (2*MW)'(f1_r_reg);
            f2_face_reg   <= best;
            f2_fdepth_reg <= fdepth;
        end
    end

    // largest even pre-shift that keeps the radicand below 2^62
    always_comb begin
        dsq = SQ_W'(f2_px_reg) + SQ_W'(f2_py_reg);
        d64 = 64'(dsq);
        hs  = '0;
        for (int k = 0; k <= MAX_HALF_SH; k++) begin
            if ((d64 >> (SQ_LIMIT - 2 * k)) == 64'd0) begin
                hs = HS_W'(k);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f3_reg.miss   <= f2_miss_reg || (dsq >= SQ_W'(f2_r2_reg));
            f3_reg.face   <= f2_face_reg;
            f3_reg.fdepth <= f2_fdepth_reg;
            f3_reg.r      <= f2_r_reg;
            f3_reg.sx     <= f2_sx_reg;
            f3_reg.sy     <= f2_sy_reg;
            f3_reg.mx     <= f2_mx_reg;
            f3_reg.my     <= f2_my_reg;
            f3_reg.hs     <= hs;
            f3_reg.dz     <= (dsq == '0);
            f3_reg.rad    <= RAD_E'(d64 << {hs, 1'b0});
        end
    end

endmodule

@@ rtl/cbcr_queue.sv @@
// short queue between the front and back pipelines
`timescale 1ns / 1ps
module cbcr_queue #(
    parameter int W = 171
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [W-1:0]     push_data,
    input  logic             pop,
    output logic [W-1:0]     pop_data,
    output cbcr_pkg::qstat_t q_stat
);
    import cbcr_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]     mem_reg [QUEUE_DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign pop_data     = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/cbcr_back.sv @@
// back pipeline: square root, normal divides and result register
`timescale 1ns / 1ps
module cbcr_back #(
    parameter int CW    = 24,
    parameter int RAD_E = 60,
    parameter int E_W   = 171,
    parameter int M_W   = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cbcr_pkg::qstat_t q_stat,
    output logic             pop,
    input  logic [E_W-1:0]   pop_data,
    input  logic [7:0]       inside_eps,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [M_W-1:0]   m_tdata
);
    import cbcr_pkg::*;

    localparam int MW   = CW - 1;
    localparam int RT_W = RAD_E / 2;
    localparam int RW   = RT_W + 2;
    localparam int ND   = MW + NORM_FRAC + 2 * MAX_HALF_SH / 2 + 1;
    localparam int DW   = (ND > RT_W + Q_W) ? ND : RT_W + Q_W;

    typedef struct packed {
        logic              miss;
        face_t             face;
        logic [CW-1:0]     fdepth;
        logic [MW-1:0]     r;
        logic              sx;
        logic              sy;
        logic [MW-1:0]     mx;
        logic [MW-1:0]     my;
        logic [HS_W-1:0]   hs;
        logic              dz;
    } side_t;

    logic en;

    // square root stages
    logic             sq_v_reg    [RT_W+1];
    logic [RW-1:0]    sq_rem_reg  [RT_W+1];
    logic [RT_W-1:0]  sq_root_reg [RT_W+1];
    logic [RAD_E-1:0] sq_rad_reg  [RT_W+1];
    side_t            sq_side_reg [RT_W+1];
    logic [RW-1:0]    sq_rem_next  [RT_W];
    logic [RT_W-1:0]  sq_root_next [RT_W];

    // divide stages
    logic             dv_v_reg    [Q_W+1];
    logic [DW-1:0]    dv_rx_reg   [Q_W+1];
    logic [DW-1:0]    dv_ry_reg   [Q_W+1];
    logic [Q_W-1:0]   dv_qx_reg   [Q_W+1];
    logic [Q_W-1:0]   dv_qy_reg   [Q_W+1];
    logic [RT_W-1:0]  dv_dq_reg   [Q_W+1];
    logic [RT_W-1:0]  dv_dist_reg [Q_W+1];
    side_t            dv_side_reg [Q_W+1];
    logic [DW-1:0]    dv_rx_next  [Q_W];
    logic [DW-1:0]    dv_ry_next  [Q_W];
    logic [Q_W-1:0]   dv_qx_next  [Q_W];
    logic [Q_W-1:0]   dv_qy_next  [Q_W];

    logic [RT_W-1:0]  dq;
    side_t            sq_out;
    side_t            fin;
    logic             in_box;
    logic [Q_W-1:0]   qcx, qcy;
    logic [CW-1:0]    depth;
    logic signed [15:0] nx, ny;
    logic             m_valid_reg;
    logic [M_W-1:0]   m_data_reg, m_data_next;

    assign en       = !m_valid_reg || m_tready;
    assign pop      = en && !q_stat.empty;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= RT_W; k++) begin
                sq_v_reg[k] <= 1'b0;
            end
            for (int j = 0; j <= Q_W; j++) begin
                dv_v_reg[j] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else if (en) begin
            sq_v_reg[0] <= pop;
            for (int k = 0; k < RT_W; k++) begin
                sq_v_reg[k+1] <= sq_v_reg[k];
            end
            dv_v_reg[0] <= sq_v_reg[RT_W];
            for (int j = 0; j < Q_W; j++) begin
                dv_v_reg[j+1] <= dv_v_reg[j];
            end
            m_valid_reg <= dv_v_reg[Q_W];
        end
    end

    // one root bit per stage
    for (genvar k = 0; k < RT_W; k++) begin : g_sqrt
        logic [RW-1:0] rem_sh;
        logic [RW-1:0] trial;
        logic          take;
        assign rem_sh = {sq_rem_reg[k][RW-3:0], sq_rad_reg[k][RAD_E-1 -: 2]};
        assign trial  = {sq_root_reg[k], 2'b01};
        assign take   = (rem_sh >= trial);
        assign sq_rem_next[k]  = take ? rem_sh - trial : rem_sh;
        assign sq_root_next[k] = {sq_root_reg[k][RT_W-2:0], take};
    end

    // one quotient bit per stage, both components side by side
    for (genvar j = 0; j < Q_W; j++) begin : g_div
        logic [DW-1:0] dsh;
        logic          tx, ty;
        assign dsh = DW'(dv_dq_reg[j]) << (Q_W - 1 - j);
        assign tx  = (dv_rx_reg[j] >= dsh);
        assign ty  = (dv_ry_reg[j] >= dsh);
        assign dv_rx_next[j] = tx ? dv_rx_reg[j] - dsh : dv_rx_reg[j];
        assign dv_ry_next[j] = ty ? dv_ry_reg[j] - dsh : dv_ry_reg[j];
        assign dv_qx_next[j] = {dv_qx_reg[j][Q_W-2:0], tx};
        assign dv_qy_next[j] = {dv_qy_reg[j][Q_W-2:0], ty};
    end

    assign dq     = sq_root_reg[RT_W];
    assign sq_out = sq_side_reg[RT_W];

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_rad_reg[0]  <= pop_data[RAD_E-1:0];
            sq_side_reg[0] <= side_t'(pop_data[E_W-1:RAD_E]);
            for (int k = 0; k < RT_W; k++) begin
                sq_rem_reg[k+1]  <= sq_rem_next[k];
                sq_root_reg[k+1] <= sq_root_next[k];
                sq_rad_reg[k+1]  <= sq_rad_reg[k] << 2;
                sq_side_reg[k+1] <= sq_side_reg[k];
            end
            // numerators carry half the divisor for round to nearest
            dv_rx_reg[0]   <= DW'((ND'(sq_out.mx) << (NORM_FRAC + int'(sq_out.hs)))
                                  + ND'(dq >> 1));
            dv_ry_reg[0]   <= DW'((ND'(sq_out.my) << (NORM_FRAC + int'(sq_out.hs)))
                                  + ND'(dq >> 1));
            dv_qx_reg[0]   <= '0;
            dv_qy_reg[0]   <= '0;
            dv_dq_reg[0]   <= dq;
            dv_dist_reg[0] <= dq >> sq_out.hs;
            dv_side_reg[0] <= sq_out;
            for (int j = 0; j < Q_W; j++) begin
                dv_rx_reg[j+1]   <= dv_rx_next[j];
                dv_ry_reg[j+1]   <= dv_ry_next[j];
                dv_qx_reg[j+1]   <= dv_qx_next[j];
                dv_qy_reg[j+1]   <= dv_qy_next[j];
                dv_dq_reg[j+1]   <= dv_dq_reg[j];
                dv_dist_reg[j+1] <= dv_dist_reg[j];
                dv_side_reg[j+1] <= dv_side_reg[j];
            end
            m_data_reg <= m_data_next;
        end
    end

    always_comb begin
        fin    = dv_side_reg[Q_W];
        in_box = fin.dz || (dv_dist_reg[Q_W] < RT_W'(inside_eps));
        qcx    = (dv_qx_reg[Q_W] > NORM_ONE_Q) ? NORM_ONE_Q : dv_qx_reg[Q_W];
        qcy    = (dv_qy_reg[Q_W] > NORM_ONE_Q) ? NORM_ONE_Q : dv_qy_reg[Q_W];
        nx     = '0;
        ny     = '0;
        depth  = '0;
        if (!fin.miss) begin
            if (in_box) begin
                depth = fin.fdepth;
                unique case (fin.face)
                    FACE_LEFT:   nx = NORM_NEG;
                    FACE_RIGHT:  nx = NORM_POS;
                    FACE_TOP:    ny = NORM_NEG;
                    FACE_BOTTOM: ny = NORM_POS;
                    default:     nx = '0;
                endcase
            end else begin
                depth = CW'(fin.r) - CW'(dv_dist_reg[Q_W]);
                nx = fin.sx ? -$signed({1'b0, qcx}) : $signed({1'b0, qcx});
                ny = fin.sy ? -$signed({1'b0, qcy}) : $signed({1'b0, qcy});
            end
        end
        m_data_next = M_W'({ny, nx, depth, !fin.miss});
    end

endmodule
